[rtl/core/arb_pkg.sv]
// ----------------------------------------------------------------------------
// arb_pkg
// Shared types, constants and the micro-program of the arcball controller.
// ----------------------------------------------------------------------------
package arb_pkg;

  // Fixed-point format of sphere points, quaternions and matrix terms
  localparam int FRAC_BITS = 14;
  localparam int ACC_W     = 64;

  // Command codes
  localparam logic [1:0] CMD_MOVE   = 2'd0;
  localparam logic [1:0] CMD_BEGIN  = 2'd1;
  localparam logic [1:0] CMD_END    = 2'd2;
  localparam logic [1:0] CMD_UPDATE = 2'd3;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;

  // Modes of the divide and square-root unit
  localparam logic MODE_DIV  = 1'b0;
  localparam logic MODE_SQRT = 1'b1;

  // Operand codes of the multiply-accumulate program
  localparam logic [4:0] OP_F0 = 5'd0;
  localparam logic [4:0] OP_F1 = 5'd1;
  localparam logic [4:0] OP_F2 = 5'd2;
  localparam logic [4:0] OP_T0 = 5'd3;
  localparam logic [4:0] OP_T1 = 5'd4;
  localparam logic [4:0] OP_T2 = 5'd5;
  localparam logic [4:0] OP_D0 = 5'd6;
  localparam logic [4:0] OP_D1 = 5'd7;
  localparam logic [4:0] OP_D2 = 5'd8;
  localparam logic [4:0] OP_D3 = 5'd9;
  localparam logic [4:0] OP_C0 = 5'd10;
  localparam logic [4:0] OP_C1 = 5'd11;
  localparam logic [4:0] OP_C2 = 5'd12;
  localparam logic [4:0] OP_C3 = 5'd13;
  localparam logic [4:0] OP_Q0 = 5'd14;
  localparam logic [4:0] OP_Q1 = 5'd15;
  localparam logic [4:0] OP_Q2 = 5'd16;
  localparam logic [4:0] OP_Q3 = 5'd17;

  // Store kinds applied to the accumulator as it stands
  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_DRAG = 3'd1;
  localparam logic [2:0] ST_ROT  = 3'd2;
  localparam logic [2:0] ST_DIAG = 3'd3;
  localparam logic [2:0] ST_OFF  = 3'd4;

  // Program counter layout
  localparam logic [5:0] PC_MAT  = 6'd26;
  localparam logic [5:0] PC_LAST = 6'd44;

  typedef struct packed {
    logic       en;
    logic       clr;
    logic       neg;
    logic [4:0] opa;
    logic [4:0] opb;
    logic [2:0] st;
    logic [3:0] idx;
  } uop_t;

  function automatic uop_t mk(input logic en, input logic clr, input logic neg,
                              input logic [4:0] a, input logic [4:0] b,
                              input logic [2:0] st, input logic [3:0] idx);
    uop_t u;
    u.en  = en;
    u.clr = clr;
    u.neg = neg;
    u.opa = a;
    u.opb = b;
    u.st  = st;
    u.idx = idx;
    return u;
  endfunction

  // Drag quaternion, composition with the committed rotation, then matrix
  function automatic uop_t uop_at(input logic [5:0] pc);
    uop_t u;
    u = mk(1'b0, 1'b0, 1'b0, OP_F0, OP_F0, ST_NONE, 4'd0);
    case (pc)
      6'd0:  u = mk(1'b1, 1'b1, 1'b0, OP_F0, OP_T0, ST_NONE, 4'd0);
      6'd1:  u = mk(1'b1, 1'b0, 1'b0, OP_F1, OP_T1, ST_NONE, 4'd0);
      6'd2:  u = mk(1'b1, 1'b0, 1'b0, OP_F2, OP_T2, ST_NONE, 4'd0);
      6'd3:  u = mk(1'b1, 1'b1, 1'b0, OP_F1, OP_T2, ST_DRAG, 4'd0);
      6'd4:  u = mk(1'b1, 1'b0, 1'b1, OP_F2, OP_T1, ST_NONE, 4'd0);
      6'd5:  u = mk(1'b1, 1'b1, 1'b0, OP_F2, OP_T0, ST_DRAG, 4'd1);
      6'd6:  u = mk(1'b1, 1'b0, 1'b1, OP_F0, OP_T2, ST_NONE, 4'd0);
      6'd7:  u = mk(1'b1, 1'b1, 1'b0, OP_F0, OP_T1, ST_DRAG, 4'd2);
      6'd8:  u = mk(1'b1, 1'b0, 1'b1, OP_F1, OP_T0, ST_NONE, 4'd0);
      6'd9:  u = mk(1'b1, 1'b1, 1'b0, OP_D0, OP_C0, ST_DRAG, 4'd3);
      6'd10: u = mk(1'b1, 1'b0, 1'b1, OP_D1, OP_C1, ST_NONE, 4'd0);
      6'd11: u = mk(1'b1, 1'b0, 1'b1, OP_D2, OP_C2, ST_NONE, 4'd0);
      6'd12: u = mk(1'b1, 1'b0, 1'b1, OP_D3, OP_C3, ST_NONE, 4'd0);
      6'd13: u = mk(1'b1, 1'b1, 1'b0, OP_D0, OP_C1, ST_ROT,  4'd0);
      6'd14: u = mk(1'b1, 1'b0, 1'b0, OP_D1, OP_C0, ST_NONE, 4'd0);
      6'd15: u = mk(1'b1, 1'b0, 1'b0, OP_D2, OP_C3, ST_NONE, 4'd0);
      6'd16: u = mk(1'b1, 1'b0, 1'b1, OP_D3, OP_C2, ST_NONE, 4'd0);
      6'd17: u = mk(1'b1, 1'b1, 1'b0, OP_D0, OP_C2, ST_ROT,  4'd1);
      6'd18: u = mk(1'b1, 1'b0, 1'b1, OP_D1, OP_C3, ST_NONE, 4'd0);
      6'd19: u = mk(1'b1, 1'b0, 1'b0, OP_D2, OP_C0, ST_NONE, 4'd0);
      6'd20: u = mk(1'b1, 1'b0, 1'b0, OP_D3, OP_C1, ST_NONE, 4'd0);
      6'd21: u = mk(1'b1, 1'b1, 1'b0, OP_D0, OP_C3, ST_ROT,  4'd2);
      6'd22: u = mk(1'b1, 1'b0, 1'b0, OP_D1, OP_C2, ST_NONE, 4'd0);
      6'd23: u = mk(1'b1, 1'b0, 1'b1, OP_D2, OP_C1, ST_NONE, 4'd0);
      6'd24: u = mk(1'b1, 1'b0, 1'b0, OP_D3, OP_C0, ST_NONE, 4'd0);
      6'd25: u = mk(1'b0, 1'b0, 1'b0, OP_F0, OP_F0, ST_ROT,  4'd3);
      6'd26: u = mk(1'b1, 1'b1, 1'b0, OP_Q2, OP_Q2, ST_NONE, 4'd0);
      6'd27: u = mk(1'b1, 1'b0, 1'b0, OP_Q3, OP_Q3, ST_NONE, 4'd0);
      6'd28: u = mk(1'b1, 1'b1, 1'b0, OP_Q1, OP_Q2, ST_DIAG, 4'd0);
      6'd29: u = mk(1'b1, 1'b0, 1'b1, OP_Q0, OP_Q3, ST_NONE, 4'd0);
      6'd30: u = mk(1'b1, 1'b1, 1'b0, OP_Q1, OP_Q3, ST_OFF,  4'd1);
      6'd31: u = mk(1'b1, 1'b0, 1'b0, OP_Q0, OP_Q2, ST_NONE, 4'd0);
      6'd32: u = mk(1'b1, 1'b1, 1'b0, OP_Q1, OP_Q2, ST_OFF,  4'd2);
      6'd33: u = mk(1'b1, 1'b0, 1'b0, OP_Q0, OP_Q3, ST_NONE, 4'd0);
      6'd34: u = mk(1'b1, 1'b1, 1'b0, OP_Q1, OP_Q1, ST_OFF,  4'd3);
      6'd35: u = mk(1'b1, 1'b0, 1'b0, OP_Q3, OP_Q3, ST_NONE, 4'd0);
      6'd36: u = mk(1'b1, 1'b1, 1'b0, OP_Q2, OP_Q3, ST_DIAG, 4'd4);
      6'd37: u = mk(1'b1, 1'b0, 1'b1, OP_Q0, OP_Q1, ST_NONE, 4'd0);
      6'd38: u = mk(1'b1, 1'b1, 1'b0, OP_Q1, OP_Q3, ST_OFF,  4'd5);
      6'd39: u = mk(1'b1, 1'b0, 1'b1, OP_Q0, OP_Q2, ST_NONE, 4'd0);
      6'd40: u = mk(1'b1, 1'b1, 1'b0, OP_Q2, OP_Q3, ST_OFF,  4'd6);
      6'd41: u = mk(1'b1, 1'b0, 1'b0, OP_Q0, OP_Q1, ST_NONE, 4'd0);
      6'd42: u = mk(1'b1, 1'b1, 1'b0, OP_Q1, OP_Q1, ST_OFF,  4'd7);
      6'd43: u = mk(1'b1, 1'b0, 1'b0, OP_Q2, OP_Q2, ST_NONE, 4'd0);
      6'd44: u = mk(1'b0, 1'b0, 1'b0, OP_F0, OP_F0, ST_DIAG, 4'd8);
      default: u = mk(1'b0, 1'b0, 1'b0, OP_F0, OP_F0, ST_NONE, 4'd0);
    endcase
    return u;
  endfunction

  // Saturate a wide value to a symmetric limit
  function automatic logic signed [15:0] sat16(input logic signed [63:0] v,
                                               input logic signed [63:0] lim);
    logic signed [63:0] c;
    c = v;
    if (v > lim) c = lim;
    else if (v < -lim) c = -lim;
    return c[15:0];
  endfunction

endpackage

[rtl/core/arb_mac.sv]
// ----------------------------------------------------------------------------
// arb_mac
// Shared signed 32x32 multiply-accumulate unit with a registered accumulator.
// ----------------------------------------------------------------------------
module arb_mac (
  input  logic                clk,
  input  logic                en,
  input  logic                clr,
  input  logic                neg,
  input  logic signed [31:0]  opa,
  input  logic signed [31:0]  opb,
  output logic signed [63:0]  acc
);

  logic signed [63:0] acc_r;
  logic signed [63:0] acc_nxt;
  logic signed [63:0] prod;

  // Product, optionally negated, added to the cleared or held accumulator
  always_comb begin
    prod    = opa * opb;
    acc_nxt = (clr ? 64'sd0 : acc_r) + (neg ? -prod : prod);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

[rtl/core/arb_dsq.sv]
// ----------------------------------------------------------------------------
// arb_dsq
// Iterative unit for restoring division and integer square root, sharing one
// compare and subtract. Division yields 16 quotient bits, the root 32 bits.
// ----------------------------------------------------------------------------
module arb_dsq (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        mode,
  input  logic [63:0] opa,
  input  logic [31:0] opb,
  output logic        done,
  output logic [31:0] result
);

  logic [63:0] x_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [4:0]  cnt_r;
  logic        run_r;
  logic        mode_r;
  logic        done_r;
  logic [63:0] sub;
  logic [63:0] diff;
  logic        ge;

  // Divisor or trial root against the partial remainder
  always_comb begin
    sub  = (mode_r == arb_pkg::MODE_DIV) ? bit_r : (res_r + bit_r);
    ge   = (x_r >= sub);
    diff = x_r - sub;
  end

  // Control: one step a cycle until the count runs out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && (cnt_r == 5'd0)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= opa;
      res_r  <= 64'd0;
      mode_r <= mode;
      if (mode == arb_pkg::MODE_DIV) begin
        bit_r <= {17'd0, opb, 15'd0};
        cnt_r <= 5'd15;
      end else begin
        bit_r <= 64'h4000_0000_0000_0000;
        cnt_r <= 5'd31;
      end
    end else if (run_r) begin
      cnt_r <= cnt_r - 5'd1;
      if (ge) begin
        x_r <= diff;
      end
      if (mode_r == arb_pkg::MODE_DIV) begin
        res_r <= {res_r[62:0], ge};
        bit_r <= bit_r >> 1;
      end else begin
        res_r <= ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);
        bit_r <= bit_r >> 2;
      end
    end
  end

  assign done   = done_r;
  assign result = res_r[31:0];

endmodule

[rtl/core/arcball_rotation_controller.sv]
// ----------------------------------------------------------------------------
// arcball_rotation_controller
// Arcball trackball: maps mouse drags onto the unit sphere, composes the drag
// quaternion with the committed rotation and returns the rotation matrix.
// ----------------------------------------------------------------------------
// Usage: the input channel carries a command (move, begin drag, end drag,
// update) and a mouse position; every accepted item yields one result with
// the nine Q1.14 matrix entries and the drag flag. The user must set ball
// centre and radius through the APB port while the block is idle; the block
// itself does not enforce this. One item is in flight at a time: in_stall is
// high from acceptance until the result has been placed in the output
// register. Move, begin drag, end drag and an update outside a drag run only
// the matrix program on the shared multiplier. An update while dragging maps
// two points; each point uses the multiplier, up to 30 normalising shifts, at
// most one 32-step square root and two 16-step divides.
// The output register frees the core: a new item is accepted while a result
// still waits, and a finished item holds in place only if the previous result
// is stalled. Reset clears the centre, sets the radius to one, the rotations
// to identity and drops any drag; no result is pending after reset.
// ----------------------------------------------------------------------------
module arcball_rotation_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [15:0] in_mouse_x,
  input  logic signed [15:0] in_mouse_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_m00,
  output logic signed [15:0] out_m01,
  output logic signed [15:0] out_m02,
  output logic signed [15:0] out_m10,
  output logic signed [15:0] out_m11,
  output logic signed [15:0] out_m12,
  output logic signed [15:0] out_m20,
  output logic signed [15:0] out_m21,
  output logic signed [15:0] out_m22,
  output logic               out_drag_active,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  // Sequencer states
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_OFS  = 5'd1;
  localparam logic [4:0] S_R1   = 5'd2;
  localparam logic [4:0] S_R2   = 5'd3;
  localparam logic [4:0] S_R3   = 5'd4;
  localparam logic [4:0] S_RCHK = 5'd5;
  localparam logic [4:0] S_NORM = 5'd6;
  localparam logic [4:0] S_N1   = 5'd7;
  localparam logic [4:0] S_N2   = 5'd8;
  localparam logic [4:0] S_NSQ  = 5'd9;
  localparam logic [4:0] S_NW   = 5'd10;
  localparam logic [4:0] S_DIVX = 5'd11;
  localparam logic [4:0] S_WX   = 5'd12;
  localparam logic [4:0] S_DIVY = 5'd13;
  localparam logic [4:0] S_WY   = 5'd14;
  localparam logic [4:0] S_Z1   = 5'd15;
  localparam logic [4:0] S_Z2   = 5'd16;
  localparam logic [4:0] S_ZSQ  = 5'd17;
  localparam logic [4:0] S_ZW   = 5'd18;
  localparam logic [4:0] S_STORE = 5'd19;
  localparam logic [4:0] S_PROG = 5'd20;
  localparam logic [4:0] S_OUT  = 5'd21;

  localparam logic signed [63:0] ONE_SQ = 64'sd1 <<< (2 * arb_pkg::FRAC_BITS);
  localparam logic signed [63:0] ONE_V  = 64'sd1 <<< arb_pkg::FRAC_BITS;
  localparam logic signed [63:0] QMAX   = (64'sd1 <<< (arb_pkg::FRAC_BITS + 1)) - 64'sd1;
  localparam logic signed [63:0] HALF   = 64'sd1 <<< (arb_pkg::FRAC_BITS - 1);

  logic [4:0]         state_r;
  logic [5:0]         pc_r;
  logic               pt_r;
  logic               outside_r;
  logic               dragging_r;
  logic signed [15:0] cx_r, cy_r;
  logic [14:0]        rad_r;
  logic signed [15:0] now_x_r, now_y_r, down_x_r, down_y_r;
  logic signed [15:0] q_r [4];
  logic signed [15:0] c_r [4];
  logic signed [15:0] d_r [4];
  logic signed [15:0] f_r [3];
  logic signed [15:0] t_r [3];
  logic signed [15:0] mat_r [9];
  logic signed [15:0] om_r [9];
  logic               out_valid_r;
  logic               out_drag_r;
  logic [30:0]        ax_r, ay_r;
  logic               sx_r, sy_r;
  logic [31:0]        dv_r;
  logic [15:0]        bx_r, by_r, bz_r;

  logic               in_xfer;
  logic               cfg_wr;
  logic [14:0]        rad_eff;
  logic signed [15:0] px, py;
  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  arb_pkg::uop_t      uop;
  logic               mac_en, mac_clr, mac_neg;
  logic signed [31:0] mac_a, mac_b;
  logic signed [63:0] acc;
  logic               dsq_start, dsq_mode, dsq_done;
  logic [63:0]        dsq_a;
  logic [31:0]        dsq_res;
  logic signed [63:0] rnd_v;
  logic signed [15:0] st_val;
  logic signed [15:0] bxs, bys;

  assign in_xfer = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign rad_eff = (rad_r == 15'd0) ? 15'd1 : rad_r;

  // Offset of the selected point from the ball centre
  always_comb begin
    px  = pt_r ? now_x_r : down_x_r;
    py  = pt_r ? now_y_r : down_y_r;
    dx  = {px[15], px} - {cx_r[15], cx_r};
    dy  = {py[15], py} - {cy_r[15], cy_r};
    adx = dx[16] ? 17'(-dx) : 17'(dx);
    ady = dy[16] ? 17'(-dy) : 17'(dy);
  end

  // Operand bank for the micro-program
  function automatic logic signed [15:0] bank(input logic [4:0] sel,
      input logic signed [15:0] f0, input logic signed [15:0] f1,
      input logic signed [15:0] f2, input logic signed [15:0] t0,
      input logic signed [15:0] t1, input logic signed [15:0] t2,
      input logic signed [15:0] d0, input logic signed [15:0] d1,
      input logic signed [15:0] d2, input logic signed [15:0] d3,
      input logic signed [15:0] c0, input logic signed [15:0] c1,
      input logic signed [15:0] c2, input logic signed [15:0] c3,
      input logic signed [15:0] q0, input logic signed [15:0] q1,
      input logic signed [15:0] q2, input logic signed [15:0] q3);
    logic signed [15:0] v;
    case (sel)
      arb_pkg::OP_F0: v = f0;
      arb_pkg::OP_F1: v = f1;
      arb_pkg::OP_F2: v = f2;
      arb_pkg::OP_T0: v = t0;
      arb_pkg::OP_T1: v = t1;
      arb_pkg::OP_T2: v = t2;
      arb_pkg::OP_D0: v = d0;
      arb_pkg::OP_D1: v = d1;
      arb_pkg::OP_D2: v = d2;
      arb_pkg::OP_D3: v = d3;
      arb_pkg::OP_C0: v = c0;
      arb_pkg::OP_C1: v = c1;
      arb_pkg::OP_C2: v = c2;
      arb_pkg::OP_C3: v = c3;
      arb_pkg::OP_Q0: v = q0;
      arb_pkg::OP_Q1: v = q1;
      arb_pkg::OP_Q2: v = q2;
      arb_pkg::OP_Q3: v = q3;
      default:        v = 16'sd0;
    endcase
    return v;
  endfunction

  // Multiplier control for each state
  always_comb begin
    uop     = arb_pkg::uop_at(pc_r);
    mac_en  = 1'b0;
    mac_clr = 1'b0;
    mac_neg = 1'b0;
    mac_a   = 32'sd0;
    mac_b   = 32'sd0;
    case (state_r)
      S_R1, S_N1: begin
        mac_en  = 1'b1;
        mac_clr = 1'b1;
        mac_a   = {1'b0, ax_r};
        mac_b   = {1'b0, ax_r};
      end
      S_R2, S_N2: begin
        mac_en = 1'b1;
        mac_a  = {1'b0, ay_r};
        mac_b  = {1'b0, ay_r};
      end
      S_R3: begin
        mac_en  = 1'b1;
        mac_neg = 1'b1;
        mac_a   = {17'd0, rad_eff};
        mac_b   = {17'd0, rad_eff};
      end
      S_Z1: begin
        mac_en  = 1'b1;
        mac_clr = 1'b1;
        mac_a   = {16'd0, bx_r};
        mac_b   = {16'd0, bx_r};
      end
      S_Z2: begin
        mac_en = 1'b1;
        mac_a  = {16'd0, by_r};
        mac_b  = {16'd0, by_r};
      end
      S_PROG: begin
        mac_en  = uop.en;
        mac_clr = uop.clr;
        mac_neg = uop.neg;
        mac_a   = 32'(bank(uop.opa, f_r[0], f_r[1], f_r[2], t_r[0], t_r[1], t_r[2],
                  d_r[0], d_r[1], d_r[2], d_r[3], c_r[0], c_r[1], c_r[2], c_r[3],
                  q_r[0], q_r[1], q_r[2], q_r[3]));
        mac_b   = 32'(bank(uop.opb, f_r[0], f_r[1], f_r[2], t_r[0], t_r[1], t_r[2],
                  d_r[0], d_r[1], d_r[2], d_r[3], c_r[0], c_r[1], c_r[2], c_r[3],
                  q_r[0], q_r[1], q_r[2], q_r[3]));
      end
      default: begin
        mac_en = 1'b0;
      end
    endcase
  end

  arb_mac u_mac (
    .clk (clk),
    .en  (mac_en),
    .clr (mac_clr),
    .neg (mac_neg),
    .opa (mac_a),
    .opb (mac_b),
    .acc (acc)
  );

  // Divide and root requests
  always_comb begin
    dsq_start = 1'b0;
    dsq_mode  = arb_pkg::MODE_DIV;
    dsq_a     = 64'd0;
    case (state_r)
      S_NSQ: begin
        dsq_start = 1'b1;
        dsq_mode  = arb_pkg::MODE_SQRT;
        dsq_a     = acc;
      end
      S_ZSQ: begin
        dsq_start = (acc < ONE_SQ);
        dsq_mode  = arb_pkg::MODE_SQRT;
        dsq_a     = ONE_SQ - acc;
      end
      S_DIVX: begin
        dsq_start = 1'b1;
        dsq_a     = {19'd0, ax_r, 14'd0};
      end
      S_DIVY: begin
        dsq_start = 1'b1;
        dsq_a     = {19'd0, ay_r, 14'd0};
      end
      default: begin
        dsq_start = 1'b0;
      end
    endcase
  end

  arb_dsq u_dsq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (dsq_start),
    .mode   (dsq_mode),
    .opa    (dsq_a),
    .opb    (dv_r),
    .done   (dsq_done),
    .result (dsq_res)
  );

  // Rounded and saturated value of the accumulator for a program store
  always_comb begin
    rnd_v = (acc + HALF) >>> arb_pkg::FRAC_BITS;
    case (uop.st)
      arb_pkg::ST_DRAG: st_val = arb_pkg::sat16(rnd_v, ONE_V);
      arb_pkg::ST_ROT:  st_val = arb_pkg::sat16(rnd_v, QMAX);
      arb_pkg::ST_DIAG: st_val = arb_pkg::sat16(ONE_V - (rnd_v <<< 1), ONE_V);
      arb_pkg::ST_OFF:  st_val = arb_pkg::sat16(rnd_v <<< 1, ONE_V);
      default:          st_val = 16'sd0;
    endcase
    bxs = sx_r ? 16'(-bx_r) : bx_r;
    bys = sy_r ? 16'(-by_r) : by_r;
  end

  // Configuration registers
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[3:2])
      arb_pkg::REG_CENTER_X: cfg_prdata = {16'd0, cx_r};
      arb_pkg::REG_CENTER_Y: cfg_prdata = {16'd0, cy_r};
      arb_pkg::REG_RADIUS:   cfg_prdata = {17'd0, rad_r};
      default:               cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= 16'sd0;
      cy_r  <= 16'sd0;
      rad_r <= 15'd1;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        arb_pkg::REG_CENTER_X: cx_r  <= cfg_pwdata[15:0];
        arb_pkg::REG_CENTER_Y: cy_r  <= cfg_pwdata[15:0];
        arb_pkg::REG_RADIUS:   rad_r <= cfg_pwdata[14:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dragging_r  <= 1'b0;
      out_valid_r <= 1'b0;
      now_x_r     <= 16'sd0;
      now_y_r     <= 16'sd0;
      down_x_r    <= 16'sd0;
      down_y_r    <= 16'sd0;
      for (int i = 0; i < 4; i++) begin
        q_r[i] <= (i == 0) ? ONE_V[15:0] : 16'sd0;
        c_r[i] <= (i == 0) ? ONE_V[15:0] : 16'sd0;
      end
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            pc_r    <= arb_pkg::PC_MAT;
            state_r <= S_PROG;
            case (in_command)
              arb_pkg::CMD_MOVE: begin
                now_x_r <= in_mouse_x;
                now_y_r <= in_mouse_y;
              end
              arb_pkg::CMD_BEGIN: begin
                dragging_r <= 1'b1;
                down_x_r   <= now_x_r;
                down_y_r   <= now_y_r;
              end
              arb_pkg::CMD_END: begin
                dragging_r <= 1'b0;
                for (int i = 0; i < 4; i++) begin
                  c_r[i] <= q_r[i];
                end
              end
              default: begin
                if (dragging_r) begin
                  pt_r    <= 1'b0;
                  state_r <= S_OFS;
                end
              end
            endcase
          end
        end
        S_OFS: begin
          ax_r    <= {14'd0, adx};
          ay_r    <= {14'd0, ady};
          sx_r    <= dx[16];
          sy_r    <= dy[16];
          state_r <= S_R1;
        end
        S_R1: state_r <= S_R2;
        S_R2: state_r <= S_R3;
        S_R3: state_r <= S_RCHK;
        S_RCHK: begin
          outside_r <= !acc[63] && (acc != 64'sd0);
          dv_r      <= {17'd0, rad_eff};
          state_r   <= (!acc[63] && (acc != 64'sd0)) ? S_NORM : S_DIVX;
        end
        // Scale the offset up until its larger part reaches 2^30
        S_NORM: begin
          if (ax_r[30] || ay_r[30]) begin
            state_r <= S_N1;
          end else begin
            ax_r <= {ax_r[29:0], 1'b0};
            ay_r <= {ay_r[29:0], 1'b0};
          end
        end
        S_N1:  state_r <= S_N2;
        S_N2:  state_r <= S_NSQ;
        S_NSQ: state_r <= S_NW;
        S_NW: begin
          if (dsq_done) begin
            dv_r    <= dsq_res;
            state_r <= S_DIVX;
          end
        end
        S_DIVX: state_r <= S_WX;
        S_WX: begin
          if (dsq_done) begin
            bx_r    <= dsq_res[15:0];
            state_r <= S_DIVY;
          end
        end
        S_DIVY: state_r <= S_WY;
        S_WY: begin
          if (dsq_done) begin
            by_r <= dsq_res[15:0];
            if (outside_r) begin
              bz_r    <= 16'd0;
              state_r <= S_STORE;
            end else begin
              state_r <= S_Z1;
            end
          end
        end
        S_Z1: state_r <= S_Z2;
        S_Z2: state_r <= S_ZSQ;
        S_ZSQ: begin
          if (acc >= ONE_SQ) begin
            bz_r    <= 16'd0;
            state_r <= S_STORE;
          end else begin
            state_r <= S_ZW;
          end
        end
        S_ZW: begin
          if (dsq_done) begin
            bz_r    <= dsq_res[15:0];
            state_r <= S_STORE;
          end
        end
        // Signed sphere point: drag start first, then current position
        S_STORE: begin
          if (!pt_r) begin
            f_r[0]  <= bxs;
            f_r[1]  <= bys;
            f_r[2]  <= bz_r;
            pt_r    <= 1'b1;
            state_r <= S_OFS;
          end else begin
            t_r[0]  <= bxs;
            t_r[1]  <= bys;
            t_r[2]  <= bz_r;
            pc_r    <= 6'd0;
            state_r <= S_PROG;
          end
        end
        S_PROG: begin
          case (uop.st)
            arb_pkg::ST_DRAG: d_r[uop.idx[1:0]] <= st_val;
            arb_pkg::ST_ROT:  q_r[uop.idx[1:0]] <= st_val;
            arb_pkg::ST_DIAG, arb_pkg::ST_OFF: mat_r[uop.idx] <= st_val;
            default: begin
            end
          endcase
          if (pc_r == arb_pkg::PC_LAST) begin
            state_r <= S_OUT;
          end else begin
            pc_r <= pc_r + 6'd1;
          end
        end
        // Hand the result to the output register once it is free
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && (!out_valid_r || !out_stall)) begin
      for (int i = 0; i < 9; i++) begin
        om_r[i] <= mat_r[i];
      end
      out_drag_r <= dragging_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_m00         = om_r[0];
  assign out_m01         = om_r[1];
  assign out_m02         = om_r[2];
  assign out_m10         = om_r[3];
  assign out_m11         = om_r[4];
  assign out_m12         = om_r[5];
  assign out_m20         = om_r[6];
  assign out_m21         = om_r[7];
  assign out_m22         = om_r[8];
  assign out_drag_active = out_drag_r;

endmodule

[tb/sv/tb_arcball_rotation_controller.sv]
// ----------------------------------------------------------------------------
// tb_arcball_rotation_controller
// Self-checking bench: drives mouse commands with random gaps and output
// stalls, predicts the rotation matrix of every item and compares it.
// ----------------------------------------------------------------------------
module tb_arcball_rotation_controller;

  typedef struct {
    logic signed [15:0] m [9];
    logic               drag;
  } arc_result_t;

  int mismatches = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Tracks the predicted trackball state and the queue of expected matrices
  class arcball_scoreboard;
    longint cx, cy, radius;
    longint nx, ny, dx0, dy0;
    longint qnow [4];
    longint qcom [4];
    bit dragging;
    arc_result_t pending [$];

    function void clear_state();
      cx = 0; cy = 0; radius = 1;
      nx = 0; ny = 0; dx0 = 0; dy0 = 0;
      qnow = '{16384, 0, 0, 0};
      qcom = '{16384, 0, 0, 0};
      dragging = 0;
    endfunction

    function longint clampl(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Round half up, then floor shift (arithmetic shift floors)
    function longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // Projects a window point onto the unit ball
    function void to_sphere(longint mx, longint my, output longint p [3]);
      longint ddx, ddy;
      longint unsigned ax, ay, r, bx, by, big, n, sq;
      ddx = clampl(mx - cx, -2147483647, 2147483647);
      ddy = clampl(my - cy, -2147483647, 2147483647);
      ax = ddx < 0 ? -ddx : ddx;
      ay = ddy < 0 ? -ddy : ddy;
      r = radius == 0 ? 1 : radius;
      if (ax * ax + ay * ay > r * r) begin
        big = ax > ay ? ax : ay;
        while (big < (64'd1 << 30)) begin
          big <<= 1; ax <<= 1; ay <<= 1;
        end
        n = int_sqrt(ax * ax + ay * ay);
        bx = (ax << 14) / n;
        by = (ay << 14) / n;
        p[2] = 0;
      end else begin
        bx = (ax << 14) / r;
        by = (ay << 14) / r;
        sq = bx * bx + by * by;
        p[2] = sq >= 64'd268435456 ? 0 : int_sqrt(64'd268435456 - sq);
      end
      p[0] = ddx < 0 ? -longint'(bx) : longint'(bx);
      p[1] = ddy < 0 ? -longint'(by) : longint'(by);
    endfunction

    function void drag_rotation();
      longint f [3];
      longint t [3];
      longint d [4];
      longint r [4];
      to_sphere(dx0, dy0, f);
      to_sphere(nx, ny, t);
      if (!dragging) return;
      d[0] = round_shift(f[0] * t[0] + f[1] * t[1] + f[2] * t[2], 14);
      d[1] = round_shift(f[1] * t[2] - f[2] * t[1], 14);
      d[2] = round_shift(f[2] * t[0] - f[0] * t[2], 14);
      d[3] = round_shift(f[0] * t[1] - f[1] * t[0], 14);
      foreach (d[i]) d[i] = clampl(d[i], -16384, 16384);
      r[0] = d[0] * qcom[0] - d[1] * qcom[1] - d[2] * qcom[2] - d[3] * qcom[3];
      r[1] = d[0] * qcom[1] + d[1] * qcom[0] + d[2] * qcom[3] - d[3] * qcom[2];
      r[2] = d[0] * qcom[2] - d[1] * qcom[3] + d[2] * qcom[0] + d[3] * qcom[1];
      r[3] = d[0] * qcom[3] + d[1] * qcom[2] - d[2] * qcom[1] + d[3] * qcom[0];
      foreach (r[i]) qnow[i] = clampl(round_shift(r[i], 14), -32767, 32767);
    endfunction

    // Notes an accepted command and queues the matrix it yields
    function void note_command(logic [1:0] c, logic signed [15:0] x,
                               logic signed [15:0] y);
      longint w, a, b, z;
      longint m [9];
      arc_result_t e;
      case (c)
        arb_pkg::CMD_MOVE: begin nx = x; ny = y; end
        arb_pkg::CMD_BEGIN: begin dragging = 1; dx0 = nx; dy0 = ny; end
        arb_pkg::CMD_END: begin dragging = 0; qcom = qnow; end
        default: drag_rotation();
      endcase
      w = qnow[0]; a = qnow[1]; b = qnow[2]; z = qnow[3];
      m[0] = 16384 - 2 * round_shift(b * b + z * z, 14);
      m[1] = 2 * round_shift(a * b - w * z, 14);
      m[2] = 2 * round_shift(a * z + w * b, 14);
      m[3] = 2 * round_shift(a * b + w * z, 14);
      m[4] = 16384 - 2 * round_shift(a * a + z * z, 14);
      m[5] = 2 * round_shift(b * z - w * a, 14);
      m[6] = 2 * round_shift(a * z - w * b, 14);
      m[7] = 2 * round_shift(b * z + w * a, 14);
      m[8] = 16384 - 2 * round_shift(a * a + b * b, 14);
      foreach (m[i]) e.m[i] = 16'(clampl(m[i], -16384, 16384));
      e.drag = dragging;
      pending.push_back(e);
    endfunction

    task check_result(logic signed [15:0] got [9], logic drag);
      arc_result_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 0);
        return;
      end
      e = pending.pop_front();
      foreach (got[i])
        if (got[i] !== e.m[i]) report_mismatch("matrix entry", got[i], e.m[i]);
      if (drag !== e.drag) report_mismatch("drag_active", drag, e.drag);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_stall;
  logic [1:0] in_command = arb_pkg::CMD_MOVE;
  logic signed [15:0] in_mouse_x = 0, in_mouse_y = 0;
  logic out_valid, out_stall = 0;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic out_drag_active;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [3:0] cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0, cfg_prdata;
  logic cfg_pready;

  arcball_scoreboard rotation_sb;
  int idle_cycles = 0;
  int stall_mode = 0;

  arcball_rotation_controller uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_mouse_x(in_mouse_x), .in_mouse_y(in_mouse_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_m00(m00), .out_m01(m01), .out_m02(m02),
    .out_m10(m10), .out_m11(m11), .out_m12(m12),
    .out_m20(m20), .out_m21(m21), .out_m22(m22),
    .out_drag_active(out_drag_active),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Checks each result transfer and counts cycles without any transfer
  always @(posedge clk) begin
    logic signed [15:0] got [9];
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
        rotation_sb.check_result(got, out_drag_active);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("tb_arcball_rotation_controller: done, errors");
        $finish;
      end
    end
  end

  // Receiver stall pattern: phases of none, light and heavy stalling
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    case (idx)
      arb_pkg::REG_CENTER_X: rotation_sb.cx = longint'(signed'(value[15:0]));
      arb_pkg::REG_CENTER_Y: rotation_sb.cy = longint'(signed'(value[15:0]));
      default: rotation_sb.radius = value[14:0];
    endcase
  endtask

  // Sends one command; the burst gap is decided before raising valid
  task automatic send_command(logic [1:0] c, logic signed [15:0] x,
                              logic signed [15:0] y);
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1; in_command <= c; in_mouse_x <= x; in_mouse_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rotation_sb.note_command(c, x, y);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (rotation_sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord(int span);
    return $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2 * span) - span);
  endfunction

  // A drag gesture: move, grab, a few moves with updates, then usually a release
  task automatic drag_gesture(int span);
    send_command(arb_pkg::CMD_MOVE, rand_coord(span), rand_coord(span));
    send_command(arb_pkg::CMD_BEGIN, 16'($urandom), 16'($urandom));
    repeat ($urandom_range(1, 4)) begin
      send_command(arb_pkg::CMD_MOVE, rand_coord(span), rand_coord(span));
      send_command(arb_pkg::CMD_UPDATE, 16'($urandom), 16'($urandom));
    end
    if ($urandom_range(0, 4) != 0)
      send_command(arb_pkg::CMD_END, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int sent;
    int rad;
    rotation_sb = new();
    rotation_sb.clear_state();
    repeat (5) @(negedge clk);
    rst_n <= 1;

    // Directed: untouched registers, extremes of position and repeated commands
    send_command(arb_pkg::CMD_UPDATE, 0, 0);
    send_command(arb_pkg::CMD_END, 0, 0);
    send_command(arb_pkg::CMD_MOVE, 16'sh7fff, -16'sh8000);
    send_command(arb_pkg::CMD_BEGIN, 0, 0);
    send_command(arb_pkg::CMD_MOVE, -16'sh8000, 16'sh7fff);
    send_command(arb_pkg::CMD_UPDATE, 0, 0);
    send_command(arb_pkg::CMD_BEGIN, 0, 0);
    send_command(arb_pkg::CMD_UPDATE, -1, -1);
    send_command(arb_pkg::CMD_END, 0, 0);
    send_command(arb_pkg::CMD_END, 0, 0);
    drain();
    write_reg(arb_pkg::REG_RADIUS, 0);
    write_reg(arb_pkg::REG_CENTER_X, 32'h7fff);
    write_reg(arb_pkg::REG_CENTER_Y, 32'hffff8000);
    send_command(arb_pkg::CMD_MOVE, -16'sh8000, 16'sh7fff);
    send_command(arb_pkg::CMD_BEGIN, 0, 0);
    send_command(arb_pkg::CMD_MOVE, 16'sh7fff, 16'sh7fff);
    send_command(arb_pkg::CMD_UPDATE, 0, 0);
    send_command(arb_pkg::CMD_END, 0, 0);
    drain();
    write_reg(arb_pkg::REG_RADIUS, 32'h7fff);
    write_reg(arb_pkg::REG_CENTER_X, 0);
    write_reg(arb_pkg::REG_CENTER_Y, 0);
    send_command(arb_pkg::CMD_MOVE, 100, -200);
    send_command(arb_pkg::CMD_BEGIN, 0, 0);
    send_command(arb_pkg::CMD_MOVE, 16'sh7fff, 0);
    send_command(arb_pkg::CMD_UPDATE, 0, 0);
    send_command(arb_pkg::CMD_END, 0, 0);
    drain();

    // Random phases, each with its own ball setting
    sent = 0;
    while (sent < 2000) begin
      rad = $urandom_range(0, 3) == 0 ? $urandom_range(1, 32767) : $urandom_range(1, 400);
      write_reg(arb_pkg::REG_RADIUS, rad);
      write_reg(arb_pkg::REG_CENTER_X, $urandom_range(0, 1) ? 32'($urandom_range(0, 600)) - 300
                                                            : $urandom);
      write_reg(arb_pkg::REG_CENTER_Y, $urandom_range(0, 1) ? 32'($urandom_range(0, 600)) - 300
                                                            : $urandom);
      repeat (40) begin
        if ($urandom_range(0, 4) != 0) begin
          drag_gesture(rad + 300);
          sent += 8;
        end else begin
          send_command(2'($urandom), 16'($urandom), 16'($urandom));
          sent++;
        end
      end
      drain();
    end

    if (mismatches == 0 && rotation_sb.pending.size() == 0)
      $display("tb_arcball_rotation_controller: done, clean");
    else
      $display("tb_arcball_rotation_controller: done, errors");
    $finish;
  end

endmodule
